[design/scvp_pkg.sv]
// ----------------------------------------------------------------------------
// scvp_pkg: shared types and constants for the surface constraint block
// Widths, register indexes, age codes and the quotient step type.
// ----------------------------------------------------------------------------
package scvp_pkg;

  localparam int FracBits = 16;
  localparam int RegW     = 31;
  localparam int DataW    = 32;
  // numerator magnitude limit is 2^(62-FracBits); dividend carries FracBits more
  localparam int NumW     = 64 - FracBits;        // signed numerator width after clamp
  localparam int QBits    = 33;                   // quotient magnitude bits kept
  localparam int DivW     = 63;                   // dividend magnitude width

  typedef enum logic [1:0] {
    CfgPenalty  = 2'd0,
    CfgSingular = 2'd1,
    CfgAge      = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AgeSkip  = 2'd0,
    AgeKeep  = 2'd1,
    AgeReset = 2'd2
  } age_e;

  // state carried through one divider stage
  typedef struct packed {
    logic             vld;
    logic             apply;
    logic             neg;
    logic [DivW-1:0]  rem;     // dividend magnitude, passed through the divider stages unchanged
    logic [RegW-1:0]  dvs;
    logic [QBits-1:0] quo;
  } div_beat_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [79:0] x);
    if (x > 80'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -80'sh8000_0000) return 32'sh8000_0000;
    return x[DataW-1:0];
  endfunction

endpackage

[design/scvp_div.sv]
// ----------------------------------------------------------------------------
// scvp_div: pipelined restoring divider
// Unsigned 63/31 division, 4 quotient bits/stage, one beat per cycle while en_i.
// ----------------------------------------------------------------------------
module scvp_div import scvp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  div_beat_t       in_i,
  output div_beat_t       out_o
);
  localparam int BitsPerStg = 4;
  localparam int NStg       = (DivW + BitsPerStg - 1) / BitsPerStg;
  localparam int PadW       = NStg * BitsPerStg;

  div_beat_t stg_q [NStg];
  logic [PadW-1:0] dvd_q [NStg];
  logic [RegW:0]   rem_q [NStg];

  // each stage shifts in four dividend bits and does four trial subtracts
  for (genvar s = 0; s < NStg; s++) begin : g_stg
    div_beat_t       src;
    logic [PadW-1:0] dvd_src;
    logic [RegW:0]   rem_src;
    logic [RegW:0]   r;
    logic [RegW+1:0] t;
    logic [QBits-1:0] qo;
    if (s == 0) begin : g_first
      assign src     = in_i;
      assign dvd_src = {{(PadW-DivW){1'b0}}, in_i.rem};
      assign rem_src = '0;
    end else begin : g_next
      assign src     = stg_q[s-1];
      assign dvd_src = dvd_q[s-1];
      assign rem_src = rem_q[s-1];
    end
    // quotient top bit is sticky: once set, the quotient is past 32 bits
    always_comb begin
      r  = rem_src;
      qo = src.quo;
      for (int b = 0; b < BitsPerStg; b++) begin
        t = {r, dvd_src[PadW-1-BitsPerStg*s-b]};
        if (t >= {1'b0, 1'b0, src.dvs}) begin
          t = t - {2'b0, src.dvs};
          qo = {qo[QBits-1] | qo[QBits-2], qo[QBits-3:0], 1'b1};
        end else begin
          qo = {qo[QBits-1] | qo[QBits-2], qo[QBits-3:0], 1'b0};
        end
        r = t[RegW:0];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_q[s].vld <= 1'b0;
      end else if (en_i) begin
        stg_q[s].vld   <= src.vld;
        stg_q[s].apply <= src.apply;
        stg_q[s].neg   <= src.neg;
        stg_q[s].rem   <= src.rem;
        stg_q[s].dvs   <= src.dvs;
        stg_q[s].quo   <= qo;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvd_q[s]       <= dvd_src;
        rem_q[s]       <= r;
      end
    end
  end

  assign out_o = stg_q[NStg-1];
endmodule

[design/surface_constraint_velocity_projection_top.sv]
// ----------------------------------------------------------------------------
// surface_constraint_velocity_projection_top: velocity projection onto surface
// Projects a particle velocity onto an implicit surface constraint.
// ----------------------------------------------------------------------------
// Pipeline: input beat to output register through 2 front stages, 16 divider
// stages and 3 back stages. Throughput: one beat per cycle; the whole pipe
// advances when the output register is free or being taken.
// Reset: all valid bits clear; registers return to 15.0, 0.01 and 1e-3.
module surface_constraint_velocity_projection_top import scvp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [RegW-1:0]         cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DataW-1:0] grad_x_i,
  input  logic signed [DataW-1:0] grad_y_i,
  input  logic signed [DataW-1:0] grad_z_i,
  input  logic signed [DataW-1:0] vel_x_i,
  input  logic signed [DataW-1:0] vel_y_i,
  input  logic signed [DataW-1:0] vel_z_i,
  input  logic signed [DataW-1:0] surface_value_i,
  input  logic signed [DataW-1:0] motion_term_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] new_vel_x_o,
  output logic signed [DataW-1:0] new_vel_y_o,
  output logic signed [DataW-1:0] new_vel_z_o,
  output logic [RegW-1:0]         grad_mag_sq_o,
  output logic [1:0]              age_action_o
);
  localparam int Dly = 16 + 1; // divider stages plus sign fixup stage

  // configuration registers
  logic [RegW-1:0] pen_q, sing_q, age_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q  <= 31'd983040;
      sing_q <= 31'd655;
      age_q  <= 31'd66;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPenalty:  pen_q  <= cfg_data_i;
        CfgSingular: sing_q <= cfg_data_i;
        CfgAge:      age_q  <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // global advance: output register empty or being taken
  logic adv;
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // ---- stage 1: products ----
  logic                    v1_q;
  logic signed [63:0]      gg_q [3];
  logic signed [63:0]      gv_q [3];
  logic signed [63:0]      pf_q;
  logic signed [DataW-1:0] g1_q [3], vl1_q [3], f1_q, m1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      g1_q[0] <= grad_x_i; g1_q[1] <= grad_y_i; g1_q[2] <= grad_z_i;
      vl1_q[0] <= vel_x_i; vl1_q[1] <= vel_y_i; vl1_q[2] <= vel_z_i;
      f1_q <= surface_value_i;
      m1_q <= motion_term_i;
      gg_q[0] <= grad_x_i * grad_x_i;
      gg_q[1] <= grad_y_i * grad_y_i;
      gg_q[2] <= grad_z_i * grad_z_i;
      gv_q[0] <= grad_x_i * vel_x_i;
      gv_q[1] <= grad_y_i * vel_y_i;
      gv_q[2] <= grad_z_i * vel_z_i;
      pf_q    <= $signed({1'b0, pen_q}) * surface_value_i;
    end
  end

  // ---- stage 2: sums ----
  logic                    v2_q;
  logic [RegW-1:0]         gm2_q;
  logic signed [NumW+1:0]  num2_q;
  logic                    age2_q;
  logic signed [DataW-1:0] g2_q [3], vl2_q [3];
  logic [65:0]             sumsq;
  logic [DataW:0]          absf;
  always_comb begin
    sumsq = {2'b0, gg_q[0]} + {2'b0, gg_q[1]} + {2'b0, gg_q[2]};
    absf  = f1_q[DataW-1] ? -{f1_q[DataW-1], f1_q} : {1'b0, f1_q};
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      gm2_q  <= (|sumsq[65:RegW+FracBits]) ? {RegW{1'b1}}
                                           : sumsq[RegW+FracBits-1:FracBits];
      num2_q <= (NumW+2)'(gv_q[0] >>> FracBits) + (NumW+2)'(gv_q[1] >>> FracBits)
              + (NumW+2)'(gv_q[2] >>> FracBits) + (NumW+2)'(m1_q)
              + (NumW+2)'(pf_q >>> FracBits);
      age2_q <= absf < {2'b0, age_q};
      g2_q   <= g1_q;
      vl2_q  <= vl1_q;
    end
  end

  // ---- stage 3: clamp, magnitude, apply decision ----
  logic signed [NumW+1:0] lim;
  logic signed [NumW+1:0] numc;
  logic [DivW-1:0]        mag;
  logic                   apply3;
  div_beat_t              din;
  assign lim = (NumW+2)'(1) <<< (62 - FracBits);
  always_comb begin
    numc = num2_q;
    if (num2_q > lim) numc = lim;
    else if (num2_q < -lim) numc = -lim;
    mag    = DivW'(numc[NumW+1] ? -numc : numc) << FracBits;
    apply3 = (gm2_q != '0) && (gm2_q >= sing_q);
    din.vld   = v2_q;
    din.apply = apply3;
    din.neg   = numc[NumW+1];
    din.rem   = mag;
    din.dvs   = (gm2_q == '0) ? RegW'(1) : gm2_q;
    din.quo   = '0;
  end

  div_beat_t dout;
  scvp_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .in_i  (din),
    .out_o (dout)
  );

  // side data delay line alongside divider
  typedef struct packed {
    logic [RegW-1:0]         gm;
    logic                    age;
    logic signed [DataW-1:0] gx, gy, gz, vx, vy, vz;
  } side_t;
  side_t side_q [Dly];
  side_t side_in;
  assign side_in = '{gm: gm2_q, age: age2_q, gx: g2_q[0], gy: g2_q[1], gz: g2_q[2],
                     vx: vl2_q[0], vy: vl2_q[1], vz: vl2_q[2]};
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_in;
      for (int i = 1; i < Dly; i++) side_q[i] <= side_q[i-1];
    end
  end

  // ---- stage 4: signed, saturated quotient ----
  logic                    v4_q, ap4_q;
  logic signed [DataW-1:0] s4_q;
  logic signed [QBits:0]   qs;
  always_comb qs = dout.neg ? -$signed({1'b0, dout.quo}) : $signed({1'b0, dout.quo});
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv) v4_q <= dout.vld;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ap4_q <= dout.apply;
      s4_q  <= sat32(80'(qs));
    end
  end

  // ---- stage 5: s*g products ----
  logic                v5_q, ap5_q;
  logic signed [63:0]  sg_q [3];
  side_t               sd5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (adv) v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ap5_q <= ap4_q;
      sd5_q <= side_q[Dly-1];
      sg_q[0] <= s4_q * side_q[Dly-1].gx;
      sg_q[1] <= s4_q * side_q[Dly-1].gy;
      sg_q[2] <= s4_q * side_q[Dly-1].gz;
    end
  end

  // ---- output register: subtract and saturate, or pass velocity through ----
  logic                    ov_q;
  logic signed [DataW-1:0] nv_q [3];
  logic [RegW-1:0]         gm_q;
  logic [1:0]              act_q;
  logic signed [DataW-1:0] vin [3];
  assign vin[0] = sd5_q.vx;
  assign vin[1] = sd5_q.vy;
  assign vin[2] = sd5_q.vz;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (adv) ov_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        nv_q[i] <= ap5_q ? sat32(80'(vin[i]) - 80'(sg_q[i] >>> FracBits)) : vin[i];
      end
      gm_q  <= sd5_q.gm;
      act_q <= !ap5_q ? AgeSkip : (sd5_q.age ? AgeReset : AgeKeep);
    end
  end

  assign out_valid_o   = ov_q;
  assign new_vel_x_o   = nv_q[0];
  assign new_vel_y_o   = nv_q[1];
  assign new_vel_z_o   = nv_q[2];
  assign grad_mag_sq_o = gm_q;
  assign age_action_o  = act_q;

  // ---- assertions ----
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(new_vel_x_o))
    else $error("output changed under stall");
  a_skip_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && age_action_o == AgeSkip |-> grad_mag_sq_o < sing_q || grad_mag_sq_o == '0)
    else $error("skip with large gradient");
  a_act_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> age_action_o != 2'd3)
    else $error("bad age code");
endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: surface constraint velocity projection regression
// Streams particles through the block under random sender gaps and receiver
// stalls, predicts each corrected velocity in fixed point and checks every
// output beat in order. Runs several register settings, the extremes included.
// ----------------------------------------------------------------------------
module testbench import scvp_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CfgUnused = 2'd3;   // index past the register list
  localparam logic [RegW-1:0] RegMax = {RegW{1'b1}};
  localparam int DrainCycles = 30;

  typedef struct {
    logic signed [DataW-1:0] gx, gy, gz, vx, vy, vz, f, m;
  } particle_t;

  typedef struct {
    logic signed [DataW-1:0] nvx, nvy, nvz;
    logic [RegW-1:0]         gmag;
    logic [1:0]              age;
  } projection_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [RegW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  particle_t drv = '{default: '0};
  logic signed [DataW-1:0] nvx, nvy, nvz;
  logic [RegW-1:0] gmag;
  logic [1:0] age;

  // register copies
  logic [RegW-1:0] penalty_q = 983040, singular_q = 655, age_thr_q = 66;

  particle_t   pending_particles[$];
  projection_t expected_projections[$];
  int errors = 0;

  always #1 clk = ~clk;

  surface_constraint_velocity_projection_top i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .grad_x_i(drv.gx), .grad_y_i(drv.gy), .grad_z_i(drv.gz),
    .vel_x_i(drv.vx), .vel_y_i(drv.vy), .vel_z_i(drv.vz),
    .surface_value_i(drv.f), .motion_term_i(drv.m),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .new_vel_x_o(nvx), .new_vel_y_o(nvy), .new_vel_z_o(nvz),
    .grad_mag_sq_o(gmag), .age_action_o(age)
  );

  function automatic logic signed [DataW-1:0] clamp_word(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[DataW-1:0];
  endfunction

  // fixed-point projection of one particle
  function automatic projection_t project_velocity(particle_t p);
    longint g[3], v[3], num, s, lim, af, fv;
    longint unsigned sumsq, gm;
    projection_t r;
    g[0] = p.gx; g[1] = p.gy; g[2] = p.gz;
    v[0] = p.vx; v[1] = p.vy; v[2] = p.vz;
    fv = p.f;
    sumsq = 0;
    for (int i = 0; i < 3; i++) sumsq += longint'(g[i] * g[i]);
    gm = sumsq >> FracBits;
    if (gm > 64'h7FFF_FFFF) gm = 64'h7FFF_FFFF;
    r.nvx = p.vx; r.nvy = p.vy; r.nvz = p.vz;
    r.gmag = gm[RegW-1:0];
    r.age = AgeSkip;
    if (gm != 0 && gm >= singular_q) begin
      lim = 64'sd1 <<< (62 - FracBits);
      num = 0;
      for (int i = 0; i < 3; i++) num += (g[i] * v[i]) >>> FracBits;
      num += longint'(p.m);
      num += (longint'(penalty_q) * fv) >>> FracBits;
      if (num > lim) num = lim;
      if (num < -lim) num = -lim;
      s = clamp_word((num <<< FracBits) / longint'(gm));
      r.nvx = clamp_word(v[0] - ((s * g[0]) >>> FracBits));
      r.nvy = clamp_word(v[1] - ((s * g[1]) >>> FracBits));
      r.nvz = clamp_word(v[2] - ((s * g[2]) >>> FracBits));
      af = fv < 0 ? -fv : fv;
      r.age = (af < longint'(age_thr_q)) ? AgeReset : AgeKeep;
    end
    return r;
  endfunction

  // sender: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_projections.push_back(project_velocity(drv));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_particles.size() > 0) begin
          drv <= pending_particles.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each taken beat in order under one of four stall modes
  int stall_mode = 0, stall_cnt = 0;
  always @(posedge clk) begin
    projection_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_projections.size() == 0) begin
          $display("%0t: unexpected beat nvx=%0d", $time, nvx);
          errors++;
        end else begin
          e = expected_projections.pop_front();
          if (nvx !== e.nvx) begin
            $display("%0t: new_vel_x exp %0d got %0d", $time, e.nvx, nvx); errors++;
          end
          if (nvy !== e.nvy) begin
            $display("%0t: new_vel_y exp %0d got %0d", $time, e.nvy, nvy); errors++;
          end
          if (nvz !== e.nvz) begin
            $display("%0t: new_vel_z exp %0d got %0d", $time, e.nvz, nvz); errors++;
          end
          if (gmag !== e.gmag) begin
            $display("%0t: grad_mag_sq exp %0d got %0d", $time, e.gmag, gmag); errors++;
          end
          if (age !== e.age) begin
            $display("%0t: age_action exp %0d got %0d", $time, e.age, age); errors++;
          end
        end
      end
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_cnt % 8) < 3;
      endcase
    end
  end

  function automatic logic signed [DataW-1:0] rand_word(int kind);
    case (kind)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      2: return $signed($urandom_range(0, 32'h0000_0200)) - 32'sh0000_0100;
      default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
    endcase
  endfunction

  task automatic add_particle(logic signed [DataW-1:0] gx, gy, gz, vx, vy, vz, f, m);
    particle_t p;
    p = '{gx, gy, gz, vx, vy, vz, f, m};
    pending_particles.push_back(p);
  endtask

  task automatic add_random(int count);
    int kg, kf;
    for (int i = 0; i < count; i++) begin
      kg = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 3);
      kf = $urandom_range(0, 3);
      add_particle(rand_word(kg), rand_word(kg), rand_word(kg),
                   rand_word($urandom_range(0, 3)), rand_word($urandom_range(0, 3)),
                   rand_word($urandom_range(0, 3)), rand_word(kf),
                   rand_word($urandom_range(0, 3)));
    end
  endtask

  // wait until everything sent has come back, then let the pipe drain
  task automatic wait_idle();
    while (pending_particles.size() > 0 || in_valid || expected_projections.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [RegW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgPenalty:  penalty_q = val;
      CfgSingular: singular_q = val;
      CfgAge:      age_thr_q = val;
      default: ;
    endcase
  endtask

  localparam logic signed [DataW-1:0] MaxW = 32'sh7FFF_FFFF, MinW = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] One = 32'sh0001_0000;

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, zero gradient, below threshold, age flag both ways
    add_particle(0, 0, 0, MaxW, MinW, 5, 0, 0);
    add_particle(MinW, MinW, MinW, MaxW, MaxW, MaxW, MinW, MinW);
    add_particle(MaxW, MaxW, MaxW, MinW, MinW, MinW, MaxW, MaxW);
    add_particle(MinW, MaxW, 0, MaxW, MinW, 0, MaxW, MinW);
    add_particle(32'sd1000, 0, 0, One, One, One, 0, 0);
    add_particle(32'sd20000, 0, 0, One, One, One, 0, 0);
    add_particle(One, 0, 0, One, 0, 0, 32'sd65, 0);
    add_particle(One, 0, 0, One, 0, 0, 32'sd66, 0);
    add_particle(0, One, 0, 0, One, 0, -32'sd65, One);
    add_particle(0, 0, One, -One, -One, -One, -32'sd66, -One);
    add_particle(32'sd1, 32'sd1, 32'sd1, MaxW, MaxW, MaxW, MaxW, MaxW);
    add_particle(32'sd300, 32'sd300, 32'sd300, MaxW, MinW, MaxW, MaxW, MaxW);
    add_particle(One, One, One, MaxW, MaxW, MaxW, MaxW, MaxW);
    add_particle(-One, -One, -One, MinW, MinW, MinW, MinW, MinW);
    add_particle(32'sh0000_8000, 0, 0, 32'sh0000_7FFF, 0, 0, 0, 0);
    add_random(100);
    wait_idle();

    write_reg(CfgPenalty, '0);
    write_reg(CfgSingular, 31'd1);
    write_reg(CfgAge, '0);
    add_particle(32'sd256, 0, 0, One, 0, 0, 0, 0);
    add_particle(32'sd255, 0, 0, One, 0, 0, 0, 0);
    add_random(100);
    wait_idle();

    write_reg(CfgPenalty, RegMax);
    write_reg(CfgSingular, RegMax);
    write_reg(CfgAge, RegMax);
    add_particle(MaxW, MaxW, MaxW, One, One, One, MinW, 0);
    add_particle(One, 0, 0, One, 0, 0, MaxW, 0);
    add_random(100);
    wait_idle();

    write_reg(CfgUnused, 31'h1234_5678);
    write_reg(CfgPenalty, 31'h0000_8000);
    write_reg(CfgSingular, 31'h0001_0000);
    write_reg(CfgAge, 31'h0000_4000);
    add_random(100);
    wait_idle();

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[surface_constraint_velocity_projection_top.f]
design/scvp_pkg.sv
design/scvp_div.sv
design/surface_constraint_velocity_projection_top.sv
tb/testbench.sv
